>>> rtl/aimp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aimp_pkg
// Shared types and constants of the angle-indexed motor positioner.
// ----------------------------------------------------------------------------
package aimp_pkg;

  // Run phase of the indexing sequence
  typedef enum logic [1:0] {
    RUN_IDLE = 2'd0,
    RUN_REV  = 2'd1,
    RUN_FWD  = 2'd2
  } run_mode_t;

  // Motor drive level
  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_A    = 2'd1,
    DRV_B    = 2'd2
  } drive_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_CYCLE_ANGLE   = 3'd0;
  localparam logic [2:0] CFG_STOP_COUNT    = 3'd1;
  localparam logic [2:0] CFG_DEADBAND      = 3'd2;
  localparam logic [2:0] CFG_MAX_STEP      = 3'd3;
  localparam logic [2:0] CFG_RUN_INTERVAL  = 3'd4;
  localparam logic [2:0] CFG_HOLD_INTERVAL = 3'd5;
  localparam logic [2:0] CFG_DEBOUNCE      = 3'd6;
  localparam logic [2:0] CFG_HOLDOFF       = 3'd7;

  // Angle arithmetic
  localparam logic [9:0] FULL_TURN   = 10'd360;
  localparam logic [9:0] TWO_TURNS   = 10'd720;
  localparam logic [9:0] HALF_TURN   = 10'd180;
  localparam logic [8:0] WRAP_HIGH   = 9'd270;
  localparam logic [8:0] WRAP_LOW    = 9'd90;
  localparam logic [9:0] TRAVEL_MAX  = 10'd1023;
  localparam logic [4:0] KEY_TIME_MAX = 5'd31;

endpackage

>>> rtl/angle_index_motor_positioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_index_motor_positioner
// Tick-driven indexing controller: runs, travel counting, origin hold, set key.
// ----------------------------------------------------------------------------
// Each input beat is one control tick carrying the raw sensor word, both run
// triggers and the set key; each tick returns exactly one result beat with the
// drive level, run phase, set flag, origin and accumulated travel. A beat is
// first captured in an input register, then one pass of short logic (a 15x9
// constant multiply for the degree conversion, a few mod-360 subtractions and
// compares) updates the controller state and loads the result register. The
// block takes one beat per clock as long as the result side keeps up; a
// stalled result register holds the input register, so one beat waits there.
// Configuration registers reset to the documented defaults and are written
// through cfg_we/cfg_addr/cfg_wdata; the user must write them only while no
// ticks are in flight, which the block itself does not enforce.
module angle_index_motor_positioner
  import aimp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  // [14:0] sensor_word, [15] forward_trigger, [16] reverse_trigger,
  // [17] set_key, [23:18] zero
  input  logic [23:0] in_tdata,
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] drive, [3:2] run_phase, [4] set_active, [13:5] origin_angle,
  // [23:14] travel
  output logic [23:0] out_tdata,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);

  // Configuration registers
  logic [9:0] cycle_angle_r, stop_count_r, run_interval_r, hold_interval_r;
  logic [7:0] deadband_r, max_step_r;
  logic [4:0] debounce_r;
  logic [5:0] holdoff_ticks_r;

  // Controller state
  run_mode_t  run_r, run_nxt;
  drive_t     drive_r, drive_nxt;
  logic [8:0] last_r, last_nxt;
  logic [9:0] travel_r, travel_nxt;
  logic [8:0] origin_r, origin_nxt;
  logic [9:0] wait_r, wait_nxt;
  logic [5:0] holdoff_r, holdoff_nxt;
  logic       set_r, set_nxt;
  logic [4:0] key_time_r, key_time_nxt;
  logic       key_latched_r, key_latched_nxt;

  // Pipeline registers
  logic        in_v_r;
  logic [17:0] in_data_r;
  logic        out_v_r;
  logic [23:0] out_data_r;
  logic [23:0] out_data_nxt;
  logic        adv;

  // Advance when the input register holds a tick and the result slot frees
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_angle_r   <= 10'd360;
      stop_count_r    <= 10'd330;
      deadband_r      <= 8'd10;
      max_step_r      <= 8'd30;
      run_interval_r  <= 10'd100;
      hold_interval_r <= 10'd1000;
      debounce_r      <= 5'd20;
      holdoff_ticks_r <= 6'd50;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CYCLE_ANGLE:   cycle_angle_r   <= cfg_wdata;
        CFG_STOP_COUNT:    stop_count_r    <= cfg_wdata;
        CFG_DEADBAND:      deadband_r      <= cfg_wdata[7:0];
        CFG_MAX_STEP:      max_step_r      <= cfg_wdata[7:0];
        CFG_RUN_INTERVAL:  run_interval_r  <= cfg_wdata;
        CFG_HOLD_INTERVAL: hold_interval_r <= cfg_wdata;
        CFG_DEBOUNCE:      debounce_r      <= cfg_wdata[4:0];
        CFG_HOLDOFF:       holdoff_ticks_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // One controller tick
  always_comb begin
    logic [23:0] prod;
    logic [8:0]  angle;
    logic        fwd, rev, key, proceed, counted, drop;
    logic [4:0]  old_time;
    logic [9:0]  ca_mod, tmp, dev, step;
    logic [10:0] sum;

    prod     = {9'd0, in_data_r[14:0]} * 24'd360;
    angle    = prod[23:15];
    fwd      = in_data_r[15];
    rev      = in_data_r[16];
    key      = in_data_r[17];
    proceed  = 1'b1;
    counted  = 1'b0;
    drop     = 1'b0;
    step     = '0;
    sum      = '0;
    dev      = '0;
    tmp      = '0;
    old_time = key_time_r;

    run_nxt         = run_r;
    drive_nxt       = drive_r;
    last_nxt        = last_r;
    travel_nxt      = travel_r;
    origin_nxt      = origin_r;
    wait_nxt        = wait_r;
    holdoff_nxt     = holdoff_r;
    set_nxt         = set_r;
    key_time_nxt    = key_time_r;
    key_latched_nxt = key_latched_r;

    // Cycle angle reduced modulo one turn
    ca_mod = cycle_angle_r;
    if (ca_mod >= TWO_TURNS) begin
      ca_mod = ca_mod - TWO_TURNS;
    end else if (ca_mod >= FULL_TURN) begin
      ca_mod = ca_mod - FULL_TURN;
    end

    // Debounce the set key and toggle set mode once per press
    if (key) begin
      if (!key_latched_r) begin
        if (key_time_r < KEY_TIME_MAX) key_time_nxt = key_time_r + 5'd1;
        if (old_time > debounce_r) begin
          key_latched_nxt = 1'b1;
          set_nxt         = !set_r;
        end
      end
    end else begin
      key_latched_nxt = 1'b0;
      key_time_nxt    = '0;
    end

    // Set mode: stop and let the origin follow the shaft
    if (set_nxt) begin
      drive_nxt  = DRV_STOP;
      run_nxt    = RUN_IDLE;
      origin_nxt = angle;
      last_nxt   = angle;
      proceed    = 1'b0;
    end

    // Trigger check, gated by holdoff
    if (proceed && run_nxt == RUN_IDLE) begin
      if (holdoff_nxt != '0) begin
        holdoff_nxt = holdoff_nxt - 6'd1;
      end else if (fwd || rev) begin
        last_nxt   = angle;
        travel_nxt = '0;
        if (fwd) begin
          run_nxt = RUN_FWD;
          tmp     = {1'b0, origin_nxt} + ca_mod;
        end else begin
          run_nxt = RUN_REV;
          tmp     = {1'b0, origin_nxt} + FULL_TURN - ca_mod;
        end
        if (tmp >= FULL_TURN) tmp = tmp - FULL_TURN;
        origin_nxt = tmp[8:0];
      end
    end

    // Run sampler: accumulate travel across the wrap
    if (proceed && run_nxt != RUN_IDLE) begin
      if (wait_nxt < run_interval_r) begin
        wait_nxt = wait_nxt + 10'd1;
      end else begin
        wait_nxt = '0;
        if (angle != last_nxt) begin
          if (run_nxt == RUN_FWD) begin
            if (angle > last_nxt) begin
              step    = {1'b0, angle} - {1'b0, last_nxt};
              counted = 1'b1;
            end else if (last_nxt > WRAP_HIGH && angle < WRAP_LOW) begin
              step    = FULL_TURN - {1'b0, last_nxt} + {1'b0, angle};
              counted = 1'b1;
            end
          end else begin
            if (last_nxt > angle) step = {1'b0, last_nxt} - {1'b0, angle};
            else step = FULL_TURN - {1'b0, angle} + {1'b0, last_nxt};
            counted = 1'b1;
          end
          if (counted) begin
            if (step > {2'b00, max_step_r}) begin
              drop = 1'b1;
            end else begin
              sum = {1'b0, travel_nxt} + {1'b0, step};
              travel_nxt = (sum > {1'b0, TRAVEL_MAX}) ? TRAVEL_MAX : sum[9:0];
              last_nxt   = angle;
              if (travel_nxt >= stop_count_r) run_nxt = RUN_IDLE;
            end
          end
        end
        if (!drop) begin
          case (run_nxt)
            RUN_REV: begin
              drive_nxt   = DRV_A;
              holdoff_nxt = holdoff_ticks_r;
            end
            RUN_FWD: begin
              drive_nxt   = DRV_B;
              holdoff_nxt = holdoff_ticks_r;
            end
            default: drive_nxt = DRV_STOP;
          endcase
        end
      end
    end

    // Hold loop: deadband correction toward the origin
    if (proceed && run_nxt == RUN_IDLE) begin
      if (wait_nxt < hold_interval_r) begin
        wait_nxt = wait_nxt + 10'd1;
      end else begin
        wait_nxt = '0;
        dev = FULL_TURN - {1'b0, origin_nxt} + {1'b0, angle};
        if (dev >= FULL_TURN) dev = dev - FULL_TURN;
        if (dev > HALF_TURN) begin
          dev = FULL_TURN - dev;
          if (dev <= {2'b00, deadband_r}) begin
            drive_nxt = DRV_STOP;
          end else begin
            drive_nxt   = DRV_B;
            holdoff_nxt = holdoff_ticks_r;
          end
        end else if (dev <= {2'b00, deadband_r}) begin
          drive_nxt = DRV_STOP;
        end else begin
          drive_nxt   = DRV_A;
          holdoff_nxt = holdoff_ticks_r;
        end
      end
    end

    out_data_nxt = {travel_nxt, origin_nxt, set_nxt, run_nxt, drive_nxt};
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      run_r         <= RUN_IDLE;
      drive_r       <= DRV_STOP;
      last_r        <= '0;
      travel_r      <= '0;
      origin_r      <= '0;
      wait_r        <= '0;
      holdoff_r     <= '0;
      set_r         <= 1'b0;
      key_time_r    <= '0;
      key_latched_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (adv) begin
        out_v_r       <= 1'b1;
        run_r         <= run_nxt;
        drive_r       <= drive_nxt;
        last_r        <= last_nxt;
        travel_r      <= travel_nxt;
        origin_r      <= origin_nxt;
        wait_r        <= wait_nxt;
        holdoff_r     <= holdoff_nxt;
        set_r         <= set_nxt;
        key_time_r    <= key_time_nxt;
        key_latched_r <= key_latched_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata[17:0];
    if (adv) out_data_r <= out_data_nxt;
  end

  // Set mode keeps the motor stopped and the run idle
  a_set_stops: assert property (@(posedge clk) disable iff (!rst_n)
    set_r |-> (run_r == RUN_IDLE && drive_r == DRV_STOP))
    else $error("set mode with motor running");

  // Origin stays within one turn
  a_origin_range: assert property (@(posedge clk) disable iff (!rst_n)
    origin_r < FULL_TURN[8:0])
    else $error("origin out of range");

  // Input stalls only when a tick waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready))
    else $error("input stalled without cause");

  // A new result appears only after a tick advanced
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(adv))
    else $error("result without tick");

endmodule
